[rtl/urm_pkg.sv]
`timescale 1ns / 1ps
// Package for the UART register model: request and result types, register map and bit masks.
// No dependencies; used by urm_core and uart_register_model_unit.
package urm_pkg;

  // Request action codes
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_RXIN  = 2'd3;

  // Register map, byte offsets
  localparam logic [7:0] OFF_RBR  = 8'h00;
  localparam logic [7:0] OFF_IER  = 8'h04;
  localparam logic [7:0] OFF_IIR  = 8'h08;
  localparam logic [7:0] OFF_LCR  = 8'h0C;
  localparam logic [7:0] OFF_MCR  = 8'h10;
  localparam logic [7:0] OFF_LSR  = 8'h14;
  localparam logic [7:0] OFF_MSR  = 8'h18;
  localparam logic [7:0] OFF_SPR  = 8'h1C;
  localparam logic [7:0] OFF_ISR  = 8'h20;
  localparam logic [7:0] OFF_UMR  = 8'h24;
  localparam logic [7:0] OFF_UACR = 8'h28;

  // Register bits
  localparam logic [7:0] IER_RX_EN   = 8'h01;
  localparam logic [7:0] IER_TX_EN   = 8'h02;
  localparam logic [7:0] LSR_DREADY  = 8'h01;
  localparam logic [7:0] LSR_TXEMPTY = 8'h60;
  localparam logic [7:0] FCR_TXIRQ   = 8'h10;
  localparam logic [7:0] FCR_CLRDR   = 8'h20;
  localparam logic [7:0] IIR_NONE    = 8'h01;
  localparam logic [7:0] IIR_TX      = 8'h02;
  localparam logic [7:0] IIR_RX      = 8'h04;

  localparam int unsigned PLAIN_COUNT = 7;
  localparam int unsigned PLAIN_IDX_W = 3;
  localparam logic [8:0]  WINDOW_RESET = 9'd48;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] offset;
    logic [7:0] write_data;
    logic       rx_waiting;
    logic [7:0] rx_char;
    logic       rx_more;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_char;
    logic       rx_pop;
    logic       irq_level;
    logic       fault;
  } rsp_t;

  typedef struct packed {
    logic                   hit;
    logic [PLAIN_IDX_W-1:0] idx;
  } plain_sel_t;

  // Map an offset to one of the seven plain storage registers
  function automatic plain_sel_t plain_lookup(input logic [7:0] off);
    plain_sel_t sel;
    sel.hit = 1'b1;
    sel.idx = '0;
    case (off)
      OFF_LCR:  sel.idx = 3'd0;
      OFF_MCR:  sel.idx = 3'd1;
      OFF_MSR:  sel.idx = 3'd2;
      OFF_SPR:  sel.idx = 3'd3;
      OFF_ISR:  sel.idx = 3'd4;
      OFF_UMR:  sel.idx = 3'd5;
      OFF_UACR: sel.idx = 3'd6;
      default:  sel.hit = 1'b0;
    endcase
    return sel;
  endfunction

endpackage

[rtl/urm_core.sv]
`timescale 1ns / 1ps
// Register state of the UART model and the single-pass decode that updates it.
// Depends on urm_pkg.
module urm_core (
  input  logic          clk,
  input  logic          rst,
  input  logic [8:0]    window_size,
  input  urm_pkg::req_t req,
  input  logic          commit,
  output urm_pkg::rsp_t rsp
);
  import urm_pkg::*;

  logic [7:0] int_enable, int_enable_next;
  logic [7:0] fifo_control, fifo_control_next;
  logic [7:0] line_status, line_status_next;
  logic [7:0] plain_regs [PLAIN_COUNT];
  logic       tx_pending, tx_pending_next;
  logic       irq_line, irq_line_next;
  logic       plain_we;
  plain_sel_t psel;
  logic       rd;
  logic       in_window;

  assign psel      = plain_lookup(req.offset);
  assign rd        = (req.action == ACT_READ);
  assign in_window = ({1'b0, req.offset} < window_size);

  // Decode one request against the current state
  always_comb begin
    int_enable_next   = int_enable;
    fifo_control_next = fifo_control;
    line_status_next  = line_status;
    tx_pending_next   = tx_pending;
    irq_line_next     = irq_line;
    plain_we          = 1'b0;
    rsp               = '0;

    case (req.action)
      ACT_TICK: begin
        tx_pending_next = 1'b0;
        if (req.rx_waiting) begin
          line_status_next = line_status | LSR_DREADY;
        end
        if (req.rx_waiting && (int_enable & IER_RX_EN) != 8'h00) begin
          irq_line_next = 1'b1;
        end else if ((int_enable & IER_TX_EN) != 8'h00 &&
                     (fifo_control & FCR_TXIRQ) != 8'h00) begin
          tx_pending_next = 1'b1;
          irq_line_next   = 1'b1;
        end
      end
      ACT_RXIN: begin
        if ((int_enable & IER_RX_EN) != 8'h00) begin
          irq_line_next = 1'b1;
        end
        line_status_next = line_status | LSR_DREADY;
      end
      default: begin
        if (in_window) begin
          if (req.offset == OFF_RBR) begin
            if (rd) begin
              if (req.rx_waiting) begin
                rsp.read_data = req.rx_char;
                rsp.rx_pop    = 1'b1;
              end
              if (req.rx_waiting && req.rx_more) begin
                line_status_next = line_status | LSR_DREADY;
              end else begin
                line_status_next = line_status & ~LSR_DREADY;
              end
            end else begin
              rsp.tx_valid = 1'b1;
              rsp.tx_char  = req.write_data;
              if ((int_enable & IER_TX_EN) != 8'h00 && !tx_pending &&
                  (fifo_control & FCR_TXIRQ) != 8'h00) begin
                tx_pending_next = 1'b1;
                irq_line_next   = 1'b1;
              end
            end
          end else if (req.offset == OFF_IER) begin
            if (rd) begin
              rsp.read_data = int_enable;
            end else begin
              int_enable_next = req.write_data;
            end
          end else if (req.offset == OFF_IIR) begin
            irq_line_next = 1'b0;
            if (rd) begin
              if (req.rx_waiting) begin
                rsp.read_data = IIR_RX;
              end else if (tx_pending) begin
                rsp.read_data   = IIR_TX;
                tx_pending_next = 1'b0;
              end else begin
                rsp.read_data = IIR_NONE;
              end
            end else begin
              fifo_control_next = req.write_data;
              if ((req.write_data & FCR_CLRDR) != 8'h00) begin
                line_status_next = line_status & ~LSR_DREADY;
              end
            end
          end else if (req.offset == OFF_LSR) begin
            if (rd) begin
              line_status_next = line_status | LSR_TXEMPTY |
                                 (req.rx_waiting ? LSR_DREADY : 8'h00);
              rsp.read_data    = line_status_next;
            end else begin
              rsp.fault = 1'b1;
            end
          end else if (psel.hit) begin
            if (rd) begin
              rsp.read_data = plain_regs[psel.idx];
            end else begin
              plain_we = 1'b1;
            end
          end else begin
            rsp.fault = 1'b1;
          end
        end
      end
    endcase

    rsp.irq_level = irq_line_next;
  end

  // Commit the state update when the result moves to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      int_enable   <= '0;
      fifo_control <= '0;
      line_status  <= LSR_TXEMPTY;
      tx_pending   <= 1'b0;
      irq_line     <= 1'b0;
      for (int i = 0; i < PLAIN_COUNT; i++) begin
        plain_regs[i] <= '0;
      end
    end else if (commit) begin
      int_enable   <= int_enable_next;
      fifo_control <= fifo_control_next;
      line_status  <= line_status_next;
      tx_pending   <= tx_pending_next;
      irq_line     <= irq_line_next;
      if (plain_we) begin
        plain_regs[psel.idx] <= req.write_data;
      end
    end
  end

endmodule

[rtl/uart_register_model_unit.sv]
`timescale 1ns / 1ps
// Top level of the UART register model: input register, core decode, output register.
// Depends on urm_pkg and urm_core.
//
//  Channel   Handshake                  Payload
//  -------   -------------------------  ----------------------------------------------
//  request   in_valid / in_stall        action offset write_data rx_waiting rx_char rx_more
//  result    out_valid / out_stall      read_data tx_valid tx_char rx_pop irq_level fault
//  config    cfg_write_enable           cfg_write_data (window_size)
//
// One request per cycle while the result is not stalled; a taken request passes through the input register,
// then the decode, and its result is registered in the result register.
// A stalled result holds in the output register while one more request waits in the input register.
// Reset (rst, synchronous) empties both registers and restores the register file.
module uart_register_model_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_enable,
  input  logic [8:0] cfg_write_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] offset,
  input  logic [7:0] write_data,
  input  logic       rx_waiting,
  input  logic [7:0] rx_char,
  input  logic       rx_more,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       tx_valid,
  output logic [7:0] tx_char,
  output logic       rx_pop,
  output logic       irq_level,
  output logic       fault
);
  import urm_pkg::*;

  logic [8:0] window_size;
  req_t       req;
  logic       req_valid;
  rsp_t       rsp_comb;
  rsp_t       rsp;
  logic       out_free;
  logic       advance;

  assign out_free = !out_valid || !out_stall;
  assign advance  = req_valid && out_free;
  assign in_stall = req_valid && !out_free;

  // Hold the window size
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
    end else if (cfg_write_enable) begin
      window_size <= cfg_write_data;
    end
  end

  // Capture a request when the input register is free or drains this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req.action     <= action;
      req.offset     <= offset;
      req.write_data <= write_data;
      req.rx_waiting <= rx_waiting;
      req.rx_char    <= rx_char;
      req.rx_more    <= rx_more;
    end
  end

  urm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .window_size (window_size),
    .req         (req),
    .commit      (advance),
    .rsp         (rsp_comb)
  );

  // Advance the result register; drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_comb;
    end
  end

  assign read_data = rsp.read_data;
  assign tx_valid  = rsp.tx_valid;
  assign tx_char   = rsp.tx_char;
  assign rx_pop    = rsp.rx_pop;
  assign irq_level = rsp.irq_level;
  assign fault     = rsp.fault;

endmodule
